### hw/rtl/hmbd_pkg.sv
package hmbd_pkg;

    typedef enum logic [1:0] {
        REQ_CPU_RD = 2'd0,
        REQ_CPU_WR = 2'd1,
        REQ_DMA_RD = 2'd2,
        REQ_FLAG   = 2'd3
    } hmbd_req_t;

    typedef enum logic [2:0] {
        ROUTE_HERE   = 3'd0,
        ROUTE_CART   = 3'd1,
        ROUTE_VIDEO  = 3'd2,
        ROUTE_TIMER  = 3'd3,
        ROUTE_JOYPAD = 3'd4
    } hmbd_route_t;

    typedef enum logic [2:0] {
        SRC_ZERO,
        SRC_FF,
        SRC_WRAM,
        SRC_HRAM,
        SRC_IF,
        SRC_IE
    } hmbd_src_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } hmbd_state_t;

    typedef struct packed {
        logic        wram_en;
        logic        hram_en;
        logic        wr;
        logic        ie_wr;
        logic        if_wr;
        logic        flag_op;
        hmbd_src_t   src;
        hmbd_route_t route;
    } hmbd_ctrl_t;

    localparam logic [2:0] FLAG_INDEX_MAX = 3'd4;
    localparam logic [7:0] IF_RESET       = 8'hE1;
    localparam logic [7:0] IE_RESET       = 8'h00;
    localparam logic [2:0] REG_TOP_ONES   = 3'b111;

    function automatic logic [7:0] reg_format(input logic [7:0] data);
        return {REG_TOP_ONES, data[4:0]};
    endfunction

endpackage

### hw/rtl/handheld_memory_bus_decoder.sv
// Bus decoder for the handheld memory map: serves work RAM (and its echo), high RAM
// and the interrupt enable/flag registers, and reports cartridge, video, timer and
// joypad accesses as a route code. The accept cycle performs the single-port RAM
// access and any register update; the lookup state then takes the registered RAM
// read data into the result register once the output register is free. s_ready is
// low while a transfer is in flight and while a result cannot yet be placed in the
// output register. After reset a clearing pass zeroes both RAMs, one entry per
// cycle through all WORK_RAM_BYTES entries (8192 by default), with s_ready held low.
module handheld_memory_bus_decoder #(
    parameter int WORK_RAM_BYTES = 8192,
    parameter int HIGH_RAM_BYTES = 127
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [1:0] s_req_type,
    input  logic [15:0] s_address,
    input  logic [7:0] s_write_data,
    input  logic       s_dma_busy,
    input  logic [2:0] s_flag_index,
    input  logic       s_flag_on,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_read_data,
    output logic [2:0] m_route,
    output logic [7:0] m_enable_reg_value,
    output logic [7:0] m_flag_reg_value
);
    import hmbd_pkg::*;

    localparam int WRAM_AW = $clog2(WORK_RAM_BYTES);
    localparam int HRAM_AW = $clog2(HIGH_RAM_BYTES);

    hmbd_state_t      state_reg, state_next;
    logic [WRAM_AW-1:0] clr_cnt_reg, clr_cnt_next;
    hmbd_src_t        src_reg;
    hmbd_route_t      route_reg;
    logic [7:0]       int_enable_reg;
    logic [7:0]       int_flags_reg;
    logic             m_valid_reg;
    logic [7:0]       m_read_data_reg;
    logic [2:0]       m_route_reg;
    logic [7:0]       m_enable_reg_value_reg;
    logic [7:0]       m_flag_reg_value_reg;

    hmbd_ctrl_t       ctrl;
    logic [WRAM_AW-1:0] dec_wram_addr;
    logic [HRAM_AW-1:0] dec_hram_addr;
    logic             accept;
    logic             clearing;
    logic             clr_done;
    logic             out_load;
    logic             hram_clr_ok;
    logic             wram_en, wram_we;
    logic [WRAM_AW-1:0] wram_addr;
    logic [7:0]       wram_wdata, wram_rdata;
    logic             hram_en, hram_we;
    logic [HRAM_AW-1:0] hram_addr;
    logic [7:0]       hram_wdata, hram_rdata;
    logic [7:0]       rd_mux;

    hmbd_decode #(
        .WRAM_AW (WRAM_AW),
        .HRAM_AW (HRAM_AW)
    ) u_decode (
        .req_type   (s_req_type),
        .address    (s_address),
        .dma_busy   (s_dma_busy),
        .flag_index (s_flag_index),
        .ctrl       (ctrl),
        .wram_addr  (dec_wram_addr),
        .hram_addr  (dec_hram_addr)
    );

    assign accept      = s_valid && s_ready;
    assign clr_done    = (clr_cnt_reg == WRAM_AW'(WORK_RAM_BYTES - 1));
    assign hram_clr_ok = ({1'b0, clr_cnt_reg[HRAM_AW-1:0]} < (HRAM_AW + 1)'(HIGH_RAM_BYTES));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (clr_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        clearing = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            ST_CLEAR:  clearing = 1'b1;
            ST_IDLE:   s_ready  = 1'b1;
            ST_LOOKUP: out_load = !m_valid_reg || m_ready;
            default:   clearing = 1'b0;
        endcase
    end

    assign clr_cnt_next = clearing ? clr_cnt_reg + 1'b1 : clr_cnt_reg;

    assign wram_en    = clearing || (accept && ctrl.wram_en);
    assign wram_we    = clearing || ctrl.wr;
    assign wram_addr  = clearing ? clr_cnt_reg : dec_wram_addr;
    assign wram_wdata = clearing ? 8'h00 : s_write_data;

    assign hram_en    = (clearing && hram_clr_ok) || (accept && ctrl.hram_en);
    assign hram_we    = clearing || ctrl.wr;
    assign hram_addr  = clearing ? clr_cnt_reg[HRAM_AW-1:0] : dec_hram_addr;
    assign hram_wdata = clearing ? 8'h00 : s_write_data;

    hmbd_ram #(
        .WIDTH (8),
        .DEPTH (WORK_RAM_BYTES)
    ) u_wram (
        .aclk  (aclk),
        .en    (wram_en),
        .we    (wram_we),
        .addr  (wram_addr),
        .wdata (wram_wdata),
        .rdata (wram_rdata)
    );

    hmbd_ram #(
        .WIDTH (8),
        .DEPTH (HIGH_RAM_BYTES)
    ) u_hram (
        .aclk  (aclk),
        .en    (hram_en),
        .we    (hram_we),
        .addr  (hram_addr),
        .wdata (hram_wdata),
        .rdata (hram_rdata)
    );

    always_comb begin
        case (src_reg)
            SRC_ZERO: rd_mux = 8'h00;
            SRC_FF:   rd_mux = 8'hFF;
            SRC_WRAM: rd_mux = wram_rdata;
            SRC_HRAM: rd_mux = hram_rdata;
            SRC_IF:   rd_mux = int_flags_reg;
            SRC_IE:   rd_mux = int_enable_reg;
            default:  rd_mux = 8'h00;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            int_enable_reg <= IE_RESET;
            int_flags_reg  <= IF_RESET;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            if (accept && ctrl.ie_wr) begin
                int_enable_reg <= reg_format(s_write_data);
            end
            if (accept && ctrl.if_wr) begin
                int_flags_reg <= reg_format(s_write_data);
            end else if (accept && ctrl.flag_op) begin
                int_flags_reg[s_flag_index] <= s_flag_on;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            src_reg   <= ctrl.src;
            route_reg <= ctrl.route;
        end
        if (out_load) begin
            m_read_data_reg        <= rd_mux;
            m_route_reg            <= route_reg;
            m_enable_reg_value_reg <= int_enable_reg;
            m_flag_reg_value_reg   <= int_flags_reg;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_read_data        = m_read_data_reg;
    assign m_route            = m_route_reg;
    assign m_enable_reg_value = m_enable_reg_value_reg;
    assign m_flag_reg_value   = m_flag_reg_value_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("transfer accepted while previous one still in flight");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_flag_reg_value[7:5] == REG_TOP_ONES))
        else $error("interrupt flag register top bits not forced high");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_route != ROUTE_HERE)) |-> (m_read_data == 8'h00))
        else $error("routed access carries nonzero read data");

endmodule

### hw/rtl/hmbd_ram.sv
module hmbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;
endmodule

### hw/rtl/hmbd_decode.sv
module hmbd_decode #(
    parameter int WRAM_AW = 13,
    parameter int HRAM_AW = 7
) (
    input  logic [1:0]          req_type,
    input  logic [15:0]         address,
    input  logic                dma_busy,
    input  logic [2:0]          flag_index,
    output hmbd_pkg::hmbd_ctrl_t ctrl,
    output logic [WRAM_AW-1:0]  wram_addr,
    output logic [HRAM_AW-1:0]  hram_addr
);
    import hmbd_pkg::*;

    logic is_wr;

    assign wram_addr = address[WRAM_AW-1:0];
    assign hram_addr = address[HRAM_AW-1:0];
    assign is_wr     = (req_type == REQ_CPU_WR);

    always_comb begin
        ctrl       = '0;
        ctrl.src   = SRC_ZERO;
        ctrl.route = ROUTE_HERE;
        case (req_type)
            REQ_FLAG: begin
                ctrl.flag_op = (flag_index <= FLAG_INDEX_MAX);
            end
            REQ_DMA_RD: begin
                if (address inside {[16'h0000:16'h7FFF], [16'hA000:16'hBFFF]}) begin
                    ctrl.route = ROUTE_CART;
                end else if (address inside {[16'h8000:16'h9FFF]}) begin
                    ctrl.route = ROUTE_VIDEO;
                end else if (address inside {[16'hC000:16'hDFFF]}) begin
                    ctrl.wram_en = 1'b1;
                    ctrl.src     = SRC_WRAM;
                end else begin
                    ctrl.src = SRC_FF;
                end
            end
            default: begin
                ctrl.wr = is_wr;
                if (address inside {[16'hFF80:16'hFFFE]}) begin
                    ctrl.hram_en = 1'b1;
                    ctrl.src     = is_wr ? SRC_ZERO : SRC_HRAM;
                end else if (dma_busy) begin
                    ctrl.src = is_wr ? SRC_ZERO : SRC_FF;
                end else if (address inside {[16'h0000:16'h7FFF],
                                             [16'hA000:16'hBFFF]}) begin
                    ctrl.route = ROUTE_CART;
                end else if (address inside {[16'h8000:16'h9FFF], [16'hFE00:16'hFE9F],
                                             [16'hFF40:16'hFF4B]}) begin
                    ctrl.route = ROUTE_VIDEO;
                end else if (address inside {[16'hC000:16'hFDFF]}) begin
                    ctrl.wram_en = 1'b1;
                    ctrl.src     = is_wr ? SRC_ZERO : SRC_WRAM;
                end else if (address == 16'hFF00) begin
                    ctrl.route = ROUTE_JOYPAD;
                end else if (address inside {[16'hFF04:16'hFF07]}) begin
                    ctrl.route = ROUTE_TIMER;
                end else if (address == 16'hFF0F) begin
                    ctrl.if_wr = is_wr;
                    ctrl.src   = is_wr ? SRC_ZERO : SRC_IF;
                end else if (address == 16'hFFFF) begin
                    ctrl.ie_wr = is_wr;
                    ctrl.src   = is_wr ? SRC_ZERO : SRC_IE;
                end else begin
                    ctrl.src = is_wr ? SRC_ZERO : SRC_FF;
                end
            end
        endcase
    end
endmodule

### test/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import hmbd_pkg::*;

    typedef struct {
        hmbd_req_t   req;
        logic [15:0] addr;
        logic [7:0]  data;
        logic        dma;
        logic [2:0]  fidx;
        logic        fon;
        int unsigned gap;
    } bus_access_t;

    typedef struct {
        logic [7:0]  rdata;
        hmbd_route_t route;
        logic [7:0]  enable;
        logic [7:0]  flags;
    } bus_answer_t;

    localparam int RANDOM_ACCESSES = 1700;
    localparam logic [15:0] BOUNDARY_ADDRS [28] = '{
        16'h0000, 16'h7FFF, 16'h8000, 16'h9FFF, 16'hA000, 16'hBFFF, 16'hC000,
        16'hDFFF, 16'hE000, 16'hFDFF, 16'hFE00, 16'hFE9F, 16'hFEA0, 16'hFEFF,
        16'hFF00, 16'hFF03, 16'hFF04, 16'hFF07, 16'hFF08, 16'hFF0F, 16'hFF3F,
        16'hFF40, 16'hFF4B, 16'hFF4C, 16'hFF7F, 16'hFF80, 16'hFFFE, 16'hFFFF
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = 2'd0;
    logic [15:0] s_address = 16'h0000;
    logic [7:0]  s_write_data = 8'h00;
    logic        s_dma_busy = 1'b0;
    logic [2:0]  s_flag_index = 3'd0;
    logic        s_flag_on = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_read_data;
    logic [2:0]  m_route;
    logic [7:0]  m_enable_reg_value;
    logic [7:0]  m_flag_reg_value;

    bus_access_t access_queue[$];
    bus_answer_t answer_queue[$];
    bus_access_t next_access;
    bus_access_t taken_access;
    bus_answer_t wanted;

    logic [7:0] wram_copy [8192];
    logic [7:0] hram_copy [127];
    logic [7:0] enable_copy = 8'h00;
    logic [7:0] flags_copy = 8'hE1;

    logic        transfer_in = 1'b0;
    int unsigned gap_left = 0;
    int unsigned stall_left = 0;
    int unsigned holdoff_left = 0;
    logic        holdoff_done = 1'b0;
    int          queued_count = 0;
    int          accepted_count = 0;
    int          results_seen = 0;
    int          error_count = 0;

    handheld_memory_bus_decoder dut (.*);

    always #10 aclk = ~aclk;

    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 50) return 1;
        if (r < 85) return $urandom_range(4, 2);
        if (r < 97) return $urandom_range(15, 5);
        return $urandom_range(60, 20);
    endfunction

    function automatic logic [15:0] pick_address();
        logic [12:0] offset;
        int unsigned sel;
        sel = $urandom_range(99);
        if (sel < 15) return 16'($urandom);
        if (sel < 45) begin
            case ($urandom_range(2))
                0: offset = 13'($urandom_range(31));
                1: offset = 13'h1DE0 + 13'($urandom_range(31));
                default: offset = 13'h1FE0 + 13'($urandom_range(31));
            endcase
            if (offset < 13'h1E00 && $urandom_range(1) == 1) return 16'hE000 + 16'(offset);
            return 16'hC000 + 16'(offset);
        end
        if (sel < 65) return 16'hFF80 + 16'($urandom_range(126));
        if (sel < 80) return 16'hFF00 + 16'($urandom_range(127));
        if (sel < 90) return ($urandom_range(1) == 1) ? 16'hFFFF : 16'hFF0F;
        return BOUNDARY_ADDRS[$urandom_range(27)];
    endfunction

    task automatic queue_access(input hmbd_req_t req, input logic [15:0] addr,
                                input logic [7:0] data, input logic dma,
                                input logic [2:0] fidx, input logic fon);
        bus_access_t acc;
        acc.req  = req;
        acc.addr = addr;
        acc.data = data;
        acc.dma  = dma;
        acc.fidx = fidx;
        acc.fon  = fon;
        acc.gap  = 0;
        if ((queued_count / 150) % 3 != 0 && $urandom_range(99) < 40) acc.gap = idle_length();
        access_queue.push_back(acc);
        queued_count++;
    endtask

    function automatic bus_answer_t decode_access(input bus_access_t acc);
        bus_answer_t ans;
        logic        wr;
        ans.rdata = 8'h00;
        ans.route = ROUTE_HERE;
        wr = (acc.req == REQ_CPU_WR);
        case (acc.req)
            REQ_FLAG: begin
                if (acc.fidx <= 3'd4) flags_copy[acc.fidx] = acc.fon;
            end
            REQ_DMA_RD: begin
                if (acc.addr <= 16'h7FFF) ans.route = ROUTE_CART;
                else if (acc.addr <= 16'h9FFF) ans.route = ROUTE_VIDEO;
                else if (acc.addr <= 16'hBFFF) ans.route = ROUTE_CART;
                else if (acc.addr <= 16'hDFFF) ans.rdata = wram_copy[acc.addr[12:0]];
                else ans.rdata = 8'hFF;
            end
            default: begin
                if (acc.addr >= 16'hFF80 && acc.addr <= 16'hFFFE) begin
                    if (wr) hram_copy[acc.addr[6:0]] = acc.data;
                    else ans.rdata = hram_copy[acc.addr[6:0]];
                end else if (acc.dma) begin
                    if (!wr) ans.rdata = 8'hFF;
                end else if (acc.addr <= 16'h7FFF) begin
                    ans.route = ROUTE_CART;
                end else if (acc.addr <= 16'h9FFF) begin
                    ans.route = ROUTE_VIDEO;
                end else if (acc.addr <= 16'hBFFF) begin
                    ans.route = ROUTE_CART;
                end else if (acc.addr <= 16'hFDFF) begin
                    if (wr) wram_copy[acc.addr[12:0]] = acc.data;
                    else ans.rdata = wram_copy[acc.addr[12:0]];
                end else if (acc.addr <= 16'hFE9F) begin
                    ans.route = ROUTE_VIDEO;
                end else if (acc.addr == 16'hFF00) begin
                    ans.route = ROUTE_JOYPAD;
                end else if (acc.addr >= 16'hFF04 && acc.addr <= 16'hFF07) begin
                    ans.route = ROUTE_TIMER;
                end else if (acc.addr >= 16'hFF40 && acc.addr <= 16'hFF4B) begin
                    ans.route = ROUTE_VIDEO;
                end else if (acc.addr == 16'hFF0F) begin
                    if (wr) flags_copy = {3'b111, acc.data[4:0]};
                    else ans.rdata = flags_copy;
                end else if (acc.addr == 16'hFFFF) begin
                    if (wr) enable_copy = {3'b111, acc.data[4:0]};
                    else ans.rdata = enable_copy;
                end else if (!wr) begin
                    ans.rdata = 8'hFF;
                end
            end
        endcase
        ans.enable = enable_copy;
        ans.flags  = flags_copy;
        return ans;
    endfunction

    // hold the payload until the transfer, then idle or advance
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || transfer_in) begin
            if (gap_left != 0) begin
                s_valid <= 1'b0;
                gap_left--;
            end else if (access_queue.size() != 0) begin
                next_access = access_queue.pop_front();
                s_valid      <= 1'b1;
                s_req_type   <= next_access.req;
                s_address    <= next_access.addr;
                s_write_data <= next_access.data;
                s_dma_busy   <= next_access.dma;
                s_flag_index <= next_access.fidx;
                s_flag_on    <= next_access.fon;
                gap_left = next_access.gap;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left != 0) begin
            m_ready <= 1'b0;
            holdoff_left--;
        end else if (!holdoff_done && results_seen >= 500) begin
            m_ready <= 1'b0;
            holdoff_left = 299;
            holdoff_done = 1'b1;
        end else if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(99) < ((results_seen / 150) % 3) * 20) begin
            m_ready <= 1'b0;
            stall_left = idle_length() - 1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        transfer_in <= s_valid && s_ready;
        if (s_valid && s_ready) begin
            taken_access.req  = hmbd_req_t'(s_req_type);
            taken_access.addr = s_address;
            taken_access.data = s_write_data;
            taken_access.dma  = s_dma_busy;
            taken_access.fidx = s_flag_index;
            taken_access.fon  = s_flag_on;
            taken_access.gap  = 0;
            answer_queue.push_back(decode_access(taken_access));
            accepted_count++;
        end
        if (m_valid && m_ready) begin
            results_seen++;
            if (answer_queue.size() == 0) begin
                $error("result transfer with no access pending");
                error_count++;
            end else begin
                wanted = answer_queue.pop_front();
                if (m_read_data !== wanted.rdata) begin
                    $error("read_data: expected %02h, actual %02h", wanted.rdata, m_read_data);
                    error_count++;
                end
                if (m_route !== wanted.route) begin
                    $error("route: expected %0d, actual %0d", wanted.route, m_route);
                    error_count++;
                end
                if (m_enable_reg_value !== wanted.enable) begin
                    $error("enable_reg_value: expected %02h, actual %02h",
                           wanted.enable, m_enable_reg_value);
                    error_count++;
                end
                if (m_flag_reg_value !== wanted.flags) begin
                    $error("flag_reg_value: expected %02h, actual %02h",
                           wanted.flags, m_flag_reg_value);
                    error_count++;
                end
            end
        end
    end

    initial begin
        hmbd_req_t   req;
        int unsigned kind;
        foreach (wram_copy[i]) wram_copy[i] = 8'h00;
        foreach (hram_copy[i]) hram_copy[i] = 8'h00;

        queue_access(REQ_CPU_WR, 16'hC000, 8'hFF, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_RD, 16'hC000, 8'h00, 1'b0, 3'd7, 1'b1);
        queue_access(REQ_CPU_WR, 16'hFDFF, 8'h5A, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_RD, 16'hDDFF, 8'h00, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_DMA_RD, 16'hDDFF, 8'h00, 1'b1, 3'd0, 1'b0);
        queue_access(REQ_DMA_RD, 16'hE000, 8'h00, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_WR, 16'hFFFF, 8'hFF, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_WR, 16'hFFFF, 8'h00, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_WR, 16'hFF0F, 8'h0A, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_RD, 16'hFF0F, 8'h00, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_FLAG,   16'h0000, 8'h00, 1'b1, 3'd4, 1'b1);
        queue_access(REQ_FLAG,   16'h0000, 8'h00, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_FLAG,   16'hFFFF, 8'hFF, 1'b0, 3'd7, 1'b1);
        queue_access(REQ_CPU_WR, 16'hFFFE, 8'h3C, 1'b1, 3'd0, 1'b0);
        queue_access(REQ_CPU_RD, 16'hFFFE, 8'h00, 1'b1, 3'd0, 1'b0);
        queue_access(REQ_CPU_WR, 16'hC000, 8'h00, 1'b1, 3'd0, 1'b0);
        queue_access(REQ_CPU_RD, 16'hFFFF, 8'h00, 1'b1, 3'd0, 1'b0);
        queue_access(REQ_CPU_RD, 16'hC000, 8'h00, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_RD, 16'h0000, 8'h00, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_WR, 16'h8000, 8'hA5, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_RD, 16'hFE00, 8'h00, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_RD, 16'hFEA0, 8'h00, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_WR, 16'hFF00, 8'h30, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_RD, 16'hFF07, 8'h00, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_CPU_RD, 16'hFF01, 8'h00, 1'b0, 3'd0, 1'b0);
        queue_access(REQ_DMA_RD, 16'hA000, 8'h00, 1'b0, 3'd0, 1'b0);

        repeat (RANDOM_ACCESSES) begin
            kind = $urandom_range(99);
            if (kind < 35) req = REQ_CPU_RD;
            else if (kind < 70) req = REQ_CPU_WR;
            else if (kind < 85) req = REQ_DMA_RD;
            else req = REQ_FLAG;
            queue_access(req, pick_address(), 8'($urandom_range(255)),
                         $urandom_range(99) < 20, 3'($urandom_range(7)),
                         1'($urandom_range(1)));
        end

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        wait (accepted_count == queued_count);
        while (answer_queue.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #(20_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule

### sim.f
hw/rtl/hmbd_pkg.sv
hw/rtl/hmbd_ram.sv
hw/rtl/hmbd_decode.sv
hw/rtl/handheld_memory_bus_decoder.sv
test/tb.sv
